// ===== sv/lko_pkg.sv =====
package lko_pkg;

    localparam int KEY_W           = 31;
    localparam int STATUS_W        = 3;
    localparam int COUNT_OUT_W     = 7;
    localparam int MAX_ENTRIES_DEF = 64;

    // Operation codes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERT   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;   // latch the key compare
        logic             shift_en; // close the gap behind the matching cell
        logic             load_en;  // write the request key at load_idx
        logic [KEY_W-1:0] key;      // request key
    } t_cell_ctl;

endpackage

// ===== sv/lko_cell.sv =====
module lko_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lko_pkg::t_cell_ctl    i_ctl,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [CNT_W-1:0]      i_load_idx,
    input  logic [lko_pkg::KEY_W-1:0] i_next_key,
    input  logic                  i_seen,
    output logic                  o_seen,
    output logic                  o_match,
    output logic [lko_pkg::KEY_W-1:0] o_key
);
    import lko_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_match;
    logic             w_valid;
    logic             w_has_next;
    logic             w_load_here;

    // Position checks against the fill count
    assign w_valid     = CNT_W'(IDX) < i_count;
    assign w_has_next  = CNT_W'(IDX + 1) < i_count;
    assign w_load_here = i_load_idx == CNT_W'(IDX);

    // Match chain: true at and after the matching position
    assign o_seen  = i_seen | r_match;
    assign o_match = r_match;
    assign o_key   = r_key;

    // Compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_match <= w_valid && (r_key == i_ctl.key);
        end
    end

    // Key storage: load takes priority over the shift from the neighbor
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_en && w_load_here) begin
            r_key <= i_ctl.key;
        end else if (i_ctl.shift_en && o_seen && w_has_next) begin
            r_key <= i_next_key;
        end
    end

endmodule

// ===== sv/lru_key_order_list.sv =====
// The result strobe follows the start transfer through the compare and update states and the result registers.
// A new request is taken only once the block is back in idle; busy covers compare and update, start is taken from idle.
// Each key compare is latched in its cell, then the row shifts toward the oldest end in one step.
// Reset (synchronous, active low) empties the list; key cells are not cleared.
// The done strobe is high for one cycle only; the receiver cannot stall.
module lru_key_order_list #(
    parameter int MAX_ENTRIES = lko_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_operation,
    input  logic [lko_pkg::KEY_W-1:0]       i_key,
    output logic                            o_done,
    output logic [lko_pkg::STATUS_W-1:0]    o_status,
    output logic [lko_pkg::COUNT_OUT_W-1:0] o_entry_count,
    output logic [lko_pkg::KEY_W-1:0]       o_oldest_key,
    output logic                            o_oldest_valid
);
    import lko_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic                r_op;
    logic [KEY_W-1:0]    r_req_key;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                r_done;

    t_cell_ctl           w_ctl;
    logic [CNT_W-1:0]    w_load_idx;
    logic                w_hit;
    logic                w_full;
    logic [MAX_ENTRIES:0]  w_seen;
    logic [MAX_ENTRIES-1:0] w_match;
    logic [KEY_W-1:0]    w_keys [MAX_ENTRIES];
    logic [CNT_W+COUNT_OUT_W-1:0] w_count_ext;

    assign busy = r_state != S_IDLE;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_CMP;
            S_CMP:   n_state = S_UPD;
            S_UPD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op      <= i_operation;
            r_req_key <= i_key;
        end
    end

    // Update decision
    assign w_hit  = |w_match;
    assign w_full = r_count == CNT_W'(MAX_ENTRIES);

    always_comb begin
        n_count      = r_count;
        n_status     = ST_NOTFOUND;
        w_load_idx   = r_count;
        w_ctl.cmp_en   = r_state == S_CMP;
        w_ctl.shift_en = 1'b0;
        w_ctl.load_en  = 1'b0;
        w_ctl.key      = r_req_key;
        if (r_state == S_UPD) begin
            priority if (r_op == OP_REMOVE && w_hit) begin
                w_ctl.shift_en = 1'b1;
                n_count        = r_count - CNT_W'(1);
                n_status       = ST_REMOVED;
            end else if (r_op == OP_REMOVE) begin
                n_status = ST_NOTFOUND;
            end else if (w_hit) begin
                w_ctl.shift_en = 1'b1;
                w_ctl.load_en  = 1'b1;
                w_load_idx     = r_count - CNT_W'(1);
                n_status       = ST_HIT;
            end else if (w_full) begin
                n_status = ST_FULL;
            end else begin
                w_ctl.load_en = 1'b1;
                n_count       = r_count + CNT_W'(1);
                n_status      = ST_INSERT;
            end
        end
    end

    // Count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= r_state == S_UPD;
            if (r_state == S_UPD) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_status <= n_status;
        end
    end

    // Row of cells, oldest at position 0
    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [KEY_W-1:0] w_next;
        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_keys[g+1];
        end
        lko_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_count    (r_count),
            .i_load_idx (w_load_idx),
            .i_next_key (w_next),
            .i_seen     (w_seen[g]),
            .o_seen     (w_seen[g+1]),
            .o_match    (w_match[g]),
            .o_key      (w_keys[g])
        );
    end

    // Result ports
    assign w_count_ext    = {{COUNT_OUT_W{1'b0}}, r_count};
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_entry_count  = w_count_ext[COUNT_OUT_W-1:0];
    assign o_oldest_valid = r_count != '0;
    assign o_oldest_key   = o_oldest_valid ? w_keys[0] : '0;

endmodule

// ===== bench/lru_key_order_list_tb.sv =====
module lru_key_order_list_tb;

    import lko_pkg::*;

    localparam int TABLE_DEPTH  = MAX_ENTRIES_DEF;
    localparam int POOL_SIZE    = 96;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] count;
        logic [KEY_W-1:0]       oldest_key;
        logic                   oldest_valid;
    } t_lru_result;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   start          = 1'b0;
    logic                   i_operation    = OP_ACCESS;
    logic [KEY_W-1:0]       i_key          = '0;
    logic                   busy;
    logic                   o_done;
    logic [STATUS_W-1:0]    o_status;
    logic [COUNT_OUT_W-1:0] o_entry_count;
    logic [KEY_W-1:0]       o_oldest_key;
    logic                   o_oldest_valid;

    // Predicted key order, oldest at index 0
    logic [KEY_W-1:0] lru_order[$];
    t_lru_result      expected_results[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];
    int               idle_pct    = 0;
    int               error_count = 0;
    int               cycle_count = 0;

    lru_key_order_list i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_key          (i_key),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_oldest_key   (o_oldest_key),
        .o_oldest_valid (o_oldest_valid)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Apply one operation to the predicted order and return the result it gives
    function automatic t_lru_result lru_apply(logic op, logic [KEY_W-1:0] key);
        int          pos;
        t_lru_result res;
        pos = -1;
        foreach (lru_order[i]) begin
            if (pos < 0 && lru_order[i] == key) pos = i;
        end
        if (op == OP_REMOVE) begin
            if (pos >= 0) begin
                lru_order.delete(pos);
                res.status = ST_REMOVED;
            end else begin
                res.status = ST_NOTFOUND;
            end
        end else if (pos >= 0) begin
            // touch: move to the most recent end
            lru_order.delete(pos);
            lru_order.push_back(key);
            res.status = ST_HIT;
        end else if (lru_order.size() >= TABLE_DEPTH) begin
            res.status = ST_FULL;
        end else begin
            lru_order.push_back(key);
            res.status = ST_INSERT;
        end
        res.count        = COUNT_OUT_W'(lru_order.size());
        res.oldest_valid = (lru_order.size() > 0);
        res.oldest_key   = res.oldest_valid ? lru_order[0] : '0;
        return res;
    endfunction

    // One command transfer, then an optional random idle gap
    task automatic send_op(input logic op, input logic [KEY_W-1:0] key);
        int gap;
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        do @(posedge i_clk); while (busy);
        expected_results.push_back(lru_apply(op, key));
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() > 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [KEY_W-1:0] exp_v,
                               input logic [KEY_W-1:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_lru_result exp_r;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: expected none actual status %0d key %0h",
                         $time, o_status, o_oldest_key);
            end else begin
                exp_r = expected_results.pop_front();
                check_field("status", KEY_W'(exp_r.status), KEY_W'(o_status));
                check_field("entry_count", KEY_W'(exp_r.count), KEY_W'(o_entry_count));
                check_field("oldest_key", exp_r.oldest_key, o_oldest_key);
                check_field("oldest_valid", KEY_W'(exp_r.oldest_valid), KEY_W'(o_oldest_valid));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Key extremes, every status but full, empty list handling
    task automatic test_basic_ops();
        idle_pct = 0;
        send_op(OP_REMOVE, 31'h0000_0000);   // empty list, not found
        send_op(OP_ACCESS, 31'h0000_0000);
        send_op(OP_ACCESS, 31'h7FFF_FFFF);
        send_op(OP_ACCESS, 31'h0000_0000);   // hit on oldest, oldest moves
        send_op(OP_ACCESS, 31'h2AAA_AAAA);
        send_op(OP_ACCESS, 31'h5555_5555);
        send_op(OP_REMOVE, 31'h7FFF_FFFF);   // remove oldest
        send_op(OP_REMOVE, 31'h0001_2345);
        send_op(OP_ACCESS, 31'h5555_5555);   // hit on newest, no move
        send_op(OP_ACCESS, 31'h0000_0000);   // hit on oldest again, oldest moves
        send_op(OP_REMOVE, 31'h0000_0000);
        send_op(OP_REMOVE, 31'h2AAA_AAAA);
        send_op(OP_REMOVE, 31'h5555_5555);   // back to empty
        send_op(OP_REMOVE, 31'h5555_5555);
        send_op(OP_ACCESS, 31'h7FFF_FFFF);
        send_op(OP_REMOVE, 31'h7FFF_FFFF);
    endtask

    // Fill to capacity, refuse, touch, free a slot, drain
    task automatic test_full_table();
        logic [KEY_W-1:0] fill_keys[TABLE_DEPTH];
        idle_pct = 54;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            fill_keys[i] = {1'b1, 24'($urandom), 6'(i)};
            send_op(OP_ACCESS, fill_keys[i]);
        end
        send_op(OP_ACCESS, 31'h0000_0001);   // refused, table full
        send_op(OP_REMOVE, 31'h0000_0001);
        send_op(OP_ACCESS, fill_keys[20]);   // hit still allowed when full
        send_op(OP_REMOVE, fill_keys[0]);
        send_op(OP_ACCESS, 31'h0000_0001);
        send_op(OP_ACCESS, 31'h0000_0002);   // full again
        for (int i = 1; i < TABLE_DEPTH; i++) send_op(OP_REMOVE, fill_keys[i]);
        send_op(OP_REMOVE, 31'h0000_0001);
    endtask

    // Mostly pool keys so hits and removes are common; bursts of inserts fill the table
    task automatic test_random_mix(input int n_items, input int sender_idle_pct);
        int               remove_pct;
        logic             op;
        logic [KEY_W-1:0] key;
        idle_pct = sender_idle_pct;
        for (int i = 0; i < n_items; i++) begin
            remove_pct = ((i / 80) % 2 == 0) ? 15 : 60;
            op  = ($urandom_range(99) < remove_pct) ? OP_REMOVE : OP_ACCESS;
            key = ($urandom_range(99) < 88) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                            : KEY_W'($urandom);
            send_op(op, key);
        end
    endtask

    initial begin
        foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_full_table();
        test_random_mix(340, 0);
        wait_drained();
        test_random_mix(340, 54);
        wait_drained();
        test_random_mix(340, 12);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
